// ----- src/chisq_pkg.sv -----
`timescale 1ns / 1ps
package chisq_pkg;

   localparam int COUNT_WIDTH_DEF = 16;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int TOTAL_WIDTH     = 16;
   localparam int STAT_WIDTH      = 33;
   localparam int MAG_WIDTH       = 32;
   localparam int LEVEL_WIDTH     = 4;
   localparam int NUM_LEVELS      = 8;
   localparam int EXPECT_MIN      = 5;
   localparam int SIG_HUNDREDTHS  = 1083;

   localparam logic [10:0] LEVEL_HUNDREDTHS [NUM_LEVELS] = '{
      11'd384, 11'd502, 11'd541, 11'd663, 11'd788, 11'd914, 11'd1083, 11'd1212
   };

   typedef struct packed {
      logic neg;
      logic degen;
   } tag_type;

endpackage

// ----- src/chisq_div.sv -----
`timescale 1ns / 1ps
module chisq_div #(
   parameter int PRODW     = 80,
   parameter int DENW      = 68,
   parameter int FRAC_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  en,
   input  logic                                  in_valid,
   input  logic [PRODW-1:0]                      in_num,
   input  logic [DENW-1:0]                       in_den,
   input  chisq_pkg::tag_type                    in_tag,
   output logic                                  out_valid,
   output logic [chisq_pkg::MAG_WIDTH-1:0]       out_mag,
   output chisq_pkg::tag_type                    out_tag
);
   import chisq_pkg::*;

   localparam int QW    = MAG_WIDTH;
   localparam int XW    = PRODW + FRAC_BITS;
   localparam int SHW   = DENW + QW - FRAC_BITS;
   localparam int SATW  = (PRODW > SHW) ? PRODW : SHW;

   logic [DENW-1:0] rem_ff [0:QW];
   logic [DENW-1:0] den_ff [0:QW];
   logic [QW-1:0]   lo_ff  [0:QW];
   logic [QW-1:0]   q_ff   [0:QW];
   logic            sat_ff [0:QW];
   tag_type         tag_ff [0:QW];
   logic            vld_ff [0:QW];

   logic [XW-1:0]      x_in;
   logic [XW+DENW-1:0] x_ext;
   logic [SATW-1:0]    num_x;
   logic [SATW-1:0]    den_x;
   logic               sat_in;

   // dividend is num * 2^frac; quotient of 32 bits or saturated
   assign x_in   = {in_num, {FRAC_BITS{1'b0}}};
   assign x_ext  = {{DENW{1'b0}}, x_in};
   assign num_x  = SATW'(in_num);
   assign den_x  = SATW'(in_den) << (QW - FRAC_BITS);
   assign sat_in = (num_x >= den_x);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= x_ext[QW +: DENW];
         den_ff[0] <= in_den;
         lo_ff[0]  <= x_in[QW-1:0];
         q_ff[0]   <= '0;
         sat_ff[0] <= sat_in;
         tag_ff[0] <= in_tag;
      end
   end

   for (genvar i = 0; i < QW; i++) begin : g_step
      logic [DENW:0] trial;
      logic [DENW:0] diff;
      logic          take;

      assign trial = {rem_ff[i], lo_ff[i][QW-1-i]};
      assign diff  = trial - {1'b0, den_ff[i]};
      assign take  = (trial >= {1'b0, den_ff[i]});

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else if (en) begin
            vld_ff[i+1] <= vld_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i+1] <= take ? diff[DENW-1:0] : trial[DENW-1:0];
            den_ff[i+1] <= den_ff[i];
            lo_ff[i+1]  <= lo_ff[i];
            q_ff[i+1]   <= {q_ff[i][QW-2:0], take};
            sat_ff[i+1] <= sat_ff[i];
            tag_ff[i+1] <= tag_ff[i];
         end
      end
   end

   assign out_valid = vld_ff[QW];
   assign out_mag   = sat_ff[QW] ? {QW{1'b1}} : q_ff[QW];
   assign out_tag   = tag_ff[QW];

endmodule

// ----- src/chi_square_2x2_significance.sv -----
`timescale 1ns / 1ps
// channel  ports                                        direction
// req      req_valid req_stall req_count_a..d           in, stall out
// rsp      rsp_valid rsp_stall rsp_statistic rsp_level_code
//          rsp_significant rsp_degenerate               out, stall in
// csr      csr_we csr_wdata (total count)               in
//
// one word per cycle in and one word per cycle out while rsp is not stalled, through
// 7 arithmetic stages, 33 stages of the bit-per-stage divider, 1 level stage
// reset clears every stage valid bit and sets the total count to 1
// a stall on rsp with a word waiting freezes the whole pipeline and raises req_stall
module chi_square_2x2_significance
   import chisq_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [COUNT_WIDTH-1:0]                  req_count_a,
   input  logic [COUNT_WIDTH-1:0]                  req_count_b,
   input  logic [COUNT_WIDTH-1:0]                  req_count_c,
   input  logic [COUNT_WIDTH-1:0]                  req_count_d,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [chisq_pkg::STAT_WIDTH-1:0] rsp_statistic,
   output logic [chisq_pkg::LEVEL_WIDTH-1:0]       rsp_level_code,
   output logic                                    rsp_significant,
   output logic                                    rsp_degenerate,
   input  logic                                    csr_we,
   input  logic [chisq_pkg::TOTAL_WIDTH-1:0]       csr_wdata
);
   localparam int CW    = COUNT_WIDTH;
   localparam int MW    = CW + 1;
   localparam int PW    = 2 * MW;
   localparam int DW    = 2 * CW;
   localparam int DENW  = 2 * PW;
   localparam int E2W   = 2 * DW;
   localparam int NW    = TOTAL_WIDTH;
   localparam int PRODW = E2W + NW;
   localparam int LIMW  = NW + 3;
   localparam int CMPW  = (PW > LIMW) ? PW : LIMW;
   localparam int M100W = MAG_WIDTH + 7;
   localparam int THRW  = 11 + FRAC_BITS;
   localparam int LVW   = (M100W > THRW) ? M100W : THRW;

   logic en;
   logic [NW-1:0] total_ff;

   assign en        = !rsp_valid || !rsp_stall;
   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= NW'(1);
      end else if (csr_we) begin
         total_ff <= csr_wdata;
      end
   end

   // stage 1: margins and cross products
   logic          v1_ff;
   logic [MW-1:0] r1_ff, r2_ff, k1_ff, k2_ff;
   logic [DW-1:0] ad_ff, bc_ff;

   // stage 2: margin products, |D|
   logic          v2_ff;
   logic [PW-1:0] p11_ff, p12_ff, p21_ff, p22_ff;
   logic [DW-1:0] dabs_ff;
   tag_type       t2_ff;

   // stage 3: correction, denominator partials
   logic          v3_ff;
   logic [DW-1:0] e_ff;
   logic [PW-1:0] dll_ff, dlh_ff, dhl_ff, dhh_ff;
   tag_type       t3_ff;

   // stage 4: denominator, E^2 partials
   logic            v4_ff;
   logic [DENW-1:0] den4_ff;
   logic [DW-1:0]   ell_ff, elh_ff, ehh_ff;
   tag_type         t4_ff;

   // stage 5: E^2
   logic            v5_ff;
   logic [DENW-1:0] den5_ff;
   logic [E2W-1:0]  e2_ff;
   tag_type         t5_ff;

   // stage 6: E^2 * n partials
   logic            v6_ff;
   logic [DENW-1:0] den6_ff;
   logic [CW+NW-1:0] en_ff [4];
   tag_type         t6_ff;

   // stage 7: numerator
   logic            v7_ff;
   logic [DENW-1:0] den7_ff;
   logic [PRODW-1:0] num7_ff;
   tag_type         t7_ff;

   // stage 1 comb
   logic [MW-1:0] r1_in, r2_in, k1_in, k2_in;
   logic [DW-1:0] ad_in, bc_in;
   assign r1_in = MW'(req_count_a) + MW'(req_count_b);
   assign r2_in = MW'(req_count_c) + MW'(req_count_d);
   assign k1_in = MW'(req_count_a) + MW'(req_count_c);
   assign k2_in = MW'(req_count_b) + MW'(req_count_d);
   assign ad_in = DW'(req_count_a) * DW'(req_count_d);
   assign bc_in = DW'(req_count_b) * DW'(req_count_c);

   // stage 2 comb
   logic    neg_in;
   tag_type t2_in;
   assign neg_in      = (ad_ff < bc_ff);
   assign t2_in.neg   = neg_in;
   assign t2_in.degen = (r1_ff == '0) || (r2_ff == '0) || (k1_ff == '0) || (k2_ff == '0);

   // stage 3 comb
   logic [CMPW-1:0] lim;
   logic            plain;
   logic [DW-1:0]   half;
   logic [DW-1:0]   e_in;
   assign lim   = CMPW'(total_ff) * CMPW'(EXPECT_MIN);
   assign plain = (CMPW'(p11_ff) > lim) && (CMPW'(p12_ff) > lim) &&
                  (CMPW'(p21_ff) > lim) && (CMPW'(p22_ff) > lim);
   assign half  = DW'(total_ff >> 1);
   always_comb begin
      if (plain) begin
         e_in = dabs_ff;
      end else if (dabs_ff > half) begin
         e_in = dabs_ff - half;
      end else begin
         e_in = '0;
      end
   end

   // stage 5 and 7 comb
   logic [E2W-1:0]   e2_in;
   logic [PRODW-1:0] num_in;
   assign e2_in = E2W'(ell_ff) + (E2W'(elh_ff) << (CW + 1)) + (E2W'(ehh_ff) << DW);
   assign num_in = PRODW'(en_ff[0]) + (PRODW'(en_ff[1]) << CW) +
                   (PRODW'(en_ff[2]) << (2 * CW)) + (PRODW'(en_ff[3]) << (3 * CW));

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r1_ff   <= r1_in;
         r2_ff   <= r2_in;
         k1_ff   <= k1_in;
         k2_ff   <= k2_in;
         ad_ff   <= ad_in;
         bc_ff   <= bc_in;

         p11_ff  <= PW'(r1_ff) * PW'(k1_ff);
         p12_ff  <= PW'(r1_ff) * PW'(k2_ff);
         p21_ff  <= PW'(k1_ff) * PW'(r2_ff);
         p22_ff  <= PW'(k2_ff) * PW'(r2_ff);
         dabs_ff <= neg_in ? (bc_ff - ad_ff) : (ad_ff - bc_ff);
         t2_ff   <= t2_in;

         e_ff    <= e_in;
         dll_ff  <= PW'(p11_ff[MW-1:0])  * PW'(p22_ff[MW-1:0]);
         dlh_ff  <= PW'(p11_ff[MW-1:0])  * PW'(p22_ff[PW-1:MW]);
         dhl_ff  <= PW'(p11_ff[PW-1:MW]) * PW'(p22_ff[MW-1:0]);
         dhh_ff  <= PW'(p11_ff[PW-1:MW]) * PW'(p22_ff[PW-1:MW]);
         t3_ff   <= t2_ff;

         den4_ff <= DENW'(dll_ff) + ((DENW'(dlh_ff) + DENW'(dhl_ff)) << MW) +
                    (DENW'(dhh_ff) << PW);
         ell_ff  <= DW'(e_ff[CW-1:0])  * DW'(e_ff[CW-1:0]);
         elh_ff  <= DW'(e_ff[CW-1:0])  * DW'(e_ff[DW-1:CW]);
         ehh_ff  <= DW'(e_ff[DW-1:CW]) * DW'(e_ff[DW-1:CW]);
         t4_ff   <= t3_ff;

         den5_ff <= den4_ff;
         e2_ff   <= e2_in;
         t5_ff   <= t4_ff;

         den6_ff <= den5_ff;
         for (int i = 0; i < 4; i++) begin
            en_ff[i] <= (CW + NW)'(e2_ff[i*CW +: CW]) * (CW + NW)'(total_ff);
         end
         t6_ff   <= t5_ff;

         den7_ff <= den6_ff;
         num7_ff <= num_in;
         t7_ff   <= t6_ff;
      end
   end

   logic                 dv;
   logic [MAG_WIDTH-1:0] dmag;
   tag_type              dtag;

   chisq_div #(
      .PRODW     (PRODW),
      .DENW      (DENW),
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v7_ff),
      .in_num    (num7_ff),
      .in_den    (den7_ff),
      .in_tag    (t7_ff),
      .out_valid (dv),
      .out_mag   (dmag),
      .out_tag   (dtag)
   );

   // level stage, also the output register
   logic [LVW-1:0]         m100;
   logic [LEVEL_WIDTH-1:0] level_in;
   logic [MAG_WIDTH:0]     smag;
   logic                   out_valid_ff;
   logic [STAT_WIDTH-1:0]  stat_ff;
   logic [LEVEL_WIDTH-1:0] level_ff;
   logic                   sig_ff;
   logic                   degen_ff;

   assign m100 = LVW'(dmag) * LVW'(100);
   always_comb begin
      level_in = '0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
         if (m100 > (LVW'(LEVEL_HUNDREDTHS[i]) << FRAC_BITS)) begin
            level_in = level_in + LEVEL_WIDTH'(1);
         end
      end
   end
   assign smag = {1'b0, dmag};

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= dv;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (dtag.degen) begin
            stat_ff  <= '0;
            level_ff <= '0;
            sig_ff   <= 1'b0;
         end else begin
            stat_ff  <= dtag.neg ? (STAT_WIDTH'(0) - smag) : smag;
            level_ff <= level_in;
            sig_ff   <= (m100 > (LVW'(SIG_HUNDREDTHS) << FRAC_BITS));
         end
         degen_ff <= dtag.degen;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_statistic   = stat_ff;
   assign rsp_level_code  = level_ff;
   assign rsp_significant = sig_ff;
   assign rsp_degenerate  = degen_ff;

endmodule

// ----- src/chisq_checker.sv -----
`timescale 1ns / 1ps
module chisq_checker (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    req_stall,
   input logic                                    rsp_valid,
   input logic                                    rsp_stall,
   input logic signed [chisq_pkg::STAT_WIDTH-1:0] rsp_statistic,
   input logic [chisq_pkg::LEVEL_WIDTH-1:0]       rsp_level_code,
   input logic                                    rsp_significant,
   input logic                                    rsp_degenerate
);
   import chisq_pkg::*;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("word out after reset");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("input taken while output blocked");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_degenerate) |->
      (rsp_statistic == '0 && rsp_level_code == '0 && !rsp_significant))
      else $error("degenerate word not zero");

   a_sig_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_significant == (rsp_level_code >= LEVEL_WIDTH'(7))))
      else $error("significant flag disagrees with level");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_statistic)))
      else $error("stalled word changed");

endmodule

bind chi_square_2x2_significance chisq_checker u_chk (.*);

// ----- tb/sv/chi_square_2x2_significance_tb.sv -----
`timescale 1ns / 1ps
module chi_square_2x2_significance_tb;
   import chisq_pkg::*;

   typedef struct {
      logic [32:0] statistic;
      logic [3:0]  level_code;
      logic        significant;
      logic        degenerate;
   } chisq_word_type;

   class chisq_scoreboard;
      chisq_word_type pending[$];
      int          errors;
      logic [15:0] total;

      function new();
         pending = {};
         errors = 0;
         total = 16'd1;
      endfunction

      function void note_table(logic [15:0] a, logic [15:0] b, logic [15:0] c, logic [15:0] d);
         chisq_word_type w;
         logic [63:0] r1, r2, k1, k2, ad, bc, e, lim, mag;
         logic [255:0] num, den, q;
         logic neg;
         r1 = a + b; r2 = c + d; k1 = a + c; k2 = b + d;
         ad = a * d; bc = b * c;
         lim = 64'd5 * total;
         w.level_code = 0;
         w.significant = 0;
         w.degenerate = 0;
         if (r1 == 0 || r2 == 0 || k1 == 0 || k2 == 0) begin
            w.statistic = 0;
            w.degenerate = 1;
         end else begin
            neg = ad < bc;
            e = neg ? bc - ad : ad - bc;
            if (!(r1 * k1 > lim && r1 * k2 > lim && k1 * r2 > lim && k2 * r2 > lim)) begin
               e = (e > (total >> 1)) ? e - (total >> 1) : 0;
            end
            num = (256'(e) * 256'(e) * 256'(total)) << FRAC_BITS_DEF;
            den = 256'(r1 * k1) * 256'(r2 * k2);
            q = num / den;
            mag = (q > 256'hFFFF_FFFF) ? 64'hFFFF_FFFF : q[63:0];
            if (mag == 0) neg = 0;
            for (int i = 0; i < NUM_LEVELS; i++) begin
               if (mag * 100 > (64'(LEVEL_HUNDREDTHS[i]) << FRAC_BITS_DEF))
                  w.level_code = 4'(i + 1);
            end
            w.significant = mag * 100 > (64'(SIG_HUNDREDTHS) << FRAC_BITS_DEF);
            w.statistic = neg ? 33'(-mag) : 33'(mag);
         end
         pending.insert(pending.size(), w);
      endfunction

      function void check_word(chisq_word_type got);
         chisq_word_type want;
         if (pending.size() == 0) begin
            $error("unexpected word");
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.statistic !== want.statistic) begin
            $error("statistic exp %h got %h", want.statistic, got.statistic);
            errors++;
         end
         if (got.level_code !== want.level_code) begin
            $error("level_code exp %0d got %0d", want.level_code, got.level_code);
            errors++;
         end
         if (got.significant !== want.significant) begin
            $error("significant exp %0b got %0b", want.significant, got.significant);
            errors++;
         end
         if (got.degenerate !== want.degenerate) begin
            $error("degenerate exp %0b got %0b", want.degenerate, got.degenerate);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [15:0] req_count_a = 0, req_count_b = 0, req_count_c = 0, req_count_d = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic signed [32:0] rsp_statistic;
   logic [3:0]  rsp_level_code;
   logic        rsp_significant;
   logic        rsp_degenerate;
   logic        csr_we = 0;
   logic [15:0] csr_wdata = 0;
   int          idle_pct = 36;
   chisq_scoreboard board = new();

   chi_square_2x2_significance dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_count_a(req_count_a), .req_count_b(req_count_b),
      .req_count_c(req_count_c), .req_count_d(req_count_d),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_statistic(rsp_statistic), .rsp_level_code(rsp_level_code),
      .rsp_significant(rsp_significant), .rsp_degenerate(rsp_degenerate),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      chisq_word_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         w.statistic = rsp_statistic;
         w.level_code = rsp_level_code;
         w.significant = rsp_significant;
         w.degenerate = rsp_degenerate;
         board.check_word(w);
      end
   end

   always @(negedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < idle_pct);
   end

   task automatic send_table(logic [15:0] a, logic [15:0] b, logic [15:0] c, logic [15:0] d);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_count_a <= a; req_count_b <= b; req_count_c <= c; req_count_d <= d;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_table(a, b, c, d);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (50) @(negedge clock);
   endtask

   task automatic write_total(logic [15:0] v);
      drain();
      csr_we <= 1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 0;
      board.total = v;
   endtask

   function automatic logic [15:0] pick_count(int mode);
      case (mode)
         0: return 16'($urandom_range(20));
         1: return 16'($urandom_range(500));
         2: return 16'($urandom);
         default: return $urandom_range(1) ? 16'hFFFF : 16'h0;
      endcase
   endfunction

   task automatic random_phase(int count);
      int mode;
      for (int i = 0; i < count; i++) begin
         mode = $urandom_range(9);
         mode = mode < 4 ? 0 : mode < 7 ? 1 : mode < 9 ? 2 : 3;
         send_table(pick_count(mode), pick_count(mode), pick_count(mode), pick_count(mode));
      end
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset <= 0;
      @(negedge clock);
      send_table(0, 0, 0, 0);
      send_table(0, 5, 0, 7);
      send_table(3, 0, 4, 0);
      send_table(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_table(16'hFFFF, 0, 0, 16'hFFFF);
      send_table(0, 16'hFFFF, 16'hFFFF, 0);
      send_table(16'hFFFF, 1, 1, 16'hFFFF);
      send_table(10, 20, 30, 40);
      write_total(16'd100);
      send_table(30, 20, 10, 40);
      send_table(25, 25, 25, 25);
      send_table(26, 24, 24, 26);
      send_table(2, 3, 40, 55);
      write_total(16'hFFFF);
      send_table(1, 2, 3, 4);
      send_table(40000, 100, 100, 40000);
      send_table(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA);
      write_total(16'd1);
      send_table(1, 2, 3, 4);
      send_table(16'h8000, 1, 1, 16'h8000);
      write_total(16'd0);
      send_table(5, 6, 7, 8);
      drain();
      idle_pct = 0;
      random_phase(300);
      idle_pct = 36;
      write_total(16'd1000);
      random_phase(300);
      write_total(16'($urandom_range(65535, 1)));
      random_phase(300);
      write_total(16'd7);
      random_phase(300);
      write_total(16'hFFFF);
      random_phase(300);
      drain();
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("TB_ERROR");
      $finish;
   end
endmodule

// ----- chi_square_2x2_significance.f -----
src/chisq_pkg.sv
src/chisq_div.sv
src/chi_square_2x2_significance.sv
src/chisq_checker.sv
tb/sv/chi_square_2x2_significance_tb.sv
